// File: design/drl_pkg.sv
// Shared widths, op codes and the month offset table for the day-range income ledger.
`timescale 1ns / 1ps

package drl_pkg;

    localparam int DEF_FRAC_BITS = 24;
    localparam int DEF_NUM_YEARS = 100;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMT_W    = 20;
    localparam int INCOME_W = 64;

    typedef enum logic {
        OP_EARN    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef logic [INCOME_W-1:0] t_income;

    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [8:0] off;
        unique case (month)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd59;
            4'd4:    off = 9'd90;
            4'd5:    off = 9'd120;
            4'd6:    off = 9'd151;
            4'd7:    off = 9'd181;
            4'd8:    off = 9'd212;
            4'd9:    off = 9'd243;
            4'd10:   off = 9'd273;
            4'd11:   off = 9'd304;
            4'd12:   off = 9'd334;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: design/day_range_income_ledger_top.sv
// Top level of the day-range income ledger: per-day store with range earn and range sum.
//
//  channel   handshake              ports
//  input     start && !busy         i_op, i_open_*, i_close_*, i_amount
//  result    o_income_vld strobe    o_income (compute only, one cycle)
//
//  Reset clears the day store one entry a cycle, with busy high.
//  Compute: the range is indexed, then each day in it is read and summed into the result.
//  Earn: the range is indexed, a restoring divider splits the amount over its days, then each
//  day is read, added to and written back. A reversed range returns to idle from S_RANGE.
//  Results cannot be stalled.
`timescale 1ns / 1ps

module day_range_income_ledger_top #(
    parameter int FRAC_BITS = drl_pkg::DEF_FRAC_BITS,
    parameter int NUM_YEARS = drl_pkg::DEF_NUM_YEARS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [drl_pkg::YEAR_W-1:0]   i_open_year,
    input  logic [drl_pkg::MONTH_W-1:0]  i_open_month,
    input  logic [drl_pkg::DAY_W-1:0]    i_open_day,
    input  logic [drl_pkg::YEAR_W-1:0]   i_close_year,
    input  logic [drl_pkg::MONTH_W-1:0]  i_close_month,
    input  logic [drl_pkg::DAY_W-1:0]    i_close_day,
    input  logic [drl_pkg::AMT_W-1:0]    i_amount,
    output logic                         o_income_vld,
    output logic [drl_pkg::INCOME_W-1:0] o_income
);
    import drl_pkg::*;

    localparam int TOTAL_DAYS = 365 * NUM_YEARS + (NUM_YEARS + 3) / 4;
    localparam int IDX_W      = $clog2(TOTAL_DAYS);
    localparam int RAW_W      = IDX_W + 1;
    localparam int CNT_W      = $clog2(TOTAL_DAYS + 1);
    localparam int DIV_W      = AMT_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(DIV_W);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TOTAL_DAYS - 1);
    localparam logic [YEAR_W-1:0] LAST_YEAR = YEAR_W'(NUM_YEARS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_INDEX = 7'b0000100,
        S_RANGE = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_DRAIN = 7'b1000000
    } t_state;

    function automatic logic [IDX_W-1:0] day_index(
        input logic [YEAR_W-1:0]  year,
        input logic [MONTH_W-1:0] month,
        input logic [DAY_W-1:0]   day
    );
        logic [YEAR_W-1:0]  yc;
        logic [MONTH_W-1:0] mc;
        logic [DAY_W-1:0]   dc;
        logic [RAW_W-1:0]   raw;
        logic               leap;
        yc   = (year > LAST_YEAR) ? LAST_YEAR : year;
        mc   = (month == MONTH_W'(0)) ? MONTH_W'(1) :
               ((month > MONTH_W'(12)) ? MONTH_W'(12) : month);
        dc   = (day == DAY_W'(0)) ? DAY_W'(1) : day;
        leap = (yc[1:0] == 2'b00);
        raw  = RAW_W'(yc) * RAW_W'(365) + ((RAW_W'(yc) + RAW_W'(3)) >> 2);
        raw  = raw + RAW_W'(month_offset(mc)) + RAW_W'(leap && (mc > MONTH_W'(2)))
             + RAW_W'(dc) - RAW_W'(1);
        return (raw > RAW_W'(LAST_IDX)) ? LAST_IDX : raw[IDX_W-1:0];
    endfunction

    t_state             r_state;
    t_op                r_op;
    logic [YEAR_W-1:0]  r_open_year;
    logic [MONTH_W-1:0] r_open_month;
    logic [DAY_W-1:0]   r_open_day;
    logic [YEAR_W-1:0]  r_close_year;
    logic [MONTH_W-1:0] r_close_month;
    logic [DAY_W-1:0]   r_close_day;
    logic [AMT_W-1:0]   r_amount;
    logic [IDX_W-1:0]   r_lo;
    logic [IDX_W-1:0]   r_hi;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   r_wr_addr;
    logic               r_rd_vld;
    t_income            r_mem_q;
    t_income            r_sum;
    logic [CNT_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_vld;
    t_income            r_mem [TOTAL_DAYS];

    logic [CNT_W:0]     n_rem_sh;
    logic               n_qbit;
    logic [CNT_W-1:0]   n_rem;
    logic [INCOME_W:0]  n_entry_wide;
    t_income            n_entry;
    logic [INCOME_W:0]  n_sum_wide;
    t_income            n_sum;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_income            mem_wdata;

    assign n_rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign n_qbit   = (n_rem_sh >= {1'b0, r_cnt});
    assign n_rem    = n_qbit ? CNT_W'(n_rem_sh - {1'b0, r_cnt}) : n_rem_sh[CNT_W-1:0];

    assign n_entry_wide = {1'b0, r_mem_q} + {1'b0, INCOME_W'(r_quo)};
    assign n_entry      = n_entry_wide[INCOME_W] ? '1 : n_entry_wide[INCOME_W-1:0];
    assign n_sum_wide   = {1'b0, r_sum} + {1'b0, r_mem_q};
    assign n_sum        = n_sum_wide[INCOME_W] ? '1 : n_sum_wide[INCOME_W-1:0];

    assign mem_we    = (r_state == S_CLEAR) || (r_rd_vld && (r_op == OP_EARN));
    assign mem_waddr = (r_state == S_CLEAR) ? r_ptr : r_wr_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            if (r_rd_vld && (r_op == OP_COMPUTE)) begin
                r_sum <= n_sum;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op          <= t_op'(i_op);
                        r_open_year   <= i_open_year;
                        r_open_month  <= i_open_month;
                        r_open_day    <= i_open_day;
                        r_close_year  <= i_close_year;
                        r_close_month <= i_close_month;
                        r_close_day   <= i_close_day;
                        r_amount      <= i_amount;
                        r_sum         <= '0;
                        r_state       <= S_INDEX;
                    end
                end
                S_CLEAR: begin
                    if (r_ptr == LAST_IDX) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + IDX_W'(1);
                    end
                end
                S_INDEX: begin
                    r_lo    <= day_index(r_open_year, r_open_month, r_open_day);
                    r_hi    <= day_index(r_close_year, r_close_month, r_close_day);
                    r_state <= S_RANGE;
                end
                S_RANGE: begin
                    r_cnt  <= CNT_W'(r_hi) - CNT_W'(r_lo) + CNT_W'(1);
                    r_ptr  <= r_lo;
                    r_quo  <= {r_amount, {FRAC_BITS{1'b0}}};
                    r_rem  <= '0;
                    r_step <= STEP_W'(DIV_W - 1);
                    if (r_lo > r_hi) begin
                        r_out_vld <= (r_op == OP_COMPUTE);
                        r_state   <= S_IDLE;
                    end else if (r_op == OP_EARN) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[DIV_W-2:0], n_qbit};
                    if (r_step == '0) begin
                        r_state <= S_WALK;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_WALK: begin
                    r_rd_vld  <= 1'b1;
                    r_wr_addr <= r_ptr;
                    if (r_ptr == r_hi) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= r_ptr + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_out_vld <= (r_op == OP_COMPUTE);
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_income_vld = r_out_vld;
    assign o_income     = r_sum;

endmodule

// File: design/drl_checker.sv
// Port-level checks for the day-range income ledger, bound to its top level.
`timescale 1ns / 1ps

module drl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_income_vld
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_income_vld |-> !busy)
        else $error("result strobe while busy");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_income_vld |=> !o_income_vld)
        else $error("result strobe held for two cycles");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_income_vld)
        else $error("result in the cycle right after accept");

endmodule

bind day_range_income_ledger_top drl_checker u_drl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_income_vld (o_income_vld)
);

// File: test/day_range_income_ledger_top_tb.sv
// Self-checking testbench for the day-range income ledger: range earn and range sum.
`timescale 1ns / 1ps

module day_range_income_ledger_top_tb;

    import drl_pkg::*;

    localparam int unsigned NUM_YEARS      = DEF_NUM_YEARS;
    localparam int unsigned FRAC_BITS      = DEF_FRAC_BITS;
    localparam int unsigned LEDGER_DAYS    = 365 * NUM_YEARS + (NUM_YEARS + 3) / 4;
    localparam int unsigned LAST_DAY       = LEDGER_DAYS - 1;
    localparam int unsigned WATCHDOG_LIMIT = 160000;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        t_op                op;
        logic [YEAR_W-1:0]  open_year;
        logic [MONTH_W-1:0] open_month;
        logic [DAY_W-1:0]   open_day;
        logic [YEAR_W-1:0]  close_year;
        logic [MONTH_W-1:0] close_month;
        logic [DAY_W-1:0]   close_day;
        logic [AMT_W-1:0]   amount;
    } t_ledger_word;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               i_op          = OP_EARN;
    logic [YEAR_W-1:0]  i_open_year   = '0;
    logic [MONTH_W-1:0] i_open_month  = '0;
    logic [DAY_W-1:0]   i_open_day    = '0;
    logic [YEAR_W-1:0]  i_close_year  = '0;
    logic [MONTH_W-1:0] i_close_month = '0;
    logic [DAY_W-1:0]   i_close_day   = '0;
    logic [AMT_W-1:0]   i_amount      = '0;
    logic               busy;
    logic               o_income_vld;
    t_income            o_income;

    t_income     ledger_day [LEDGER_DAYS];
    t_income     income_due [$];
    t_income     income_exp;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    bit          idle_on        = 1'b1;

    day_range_income_ledger_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_open_year   (i_open_year),
        .i_open_month  (i_open_month),
        .i_open_day    (i_open_day),
        .i_close_year  (i_close_year),
        .i_close_month (i_close_month),
        .i_close_day   (i_close_day),
        .i_amount      (i_amount),
        .o_income_vld  (o_income_vld),
        .o_income      (o_income)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit yoff_is_leap(int unsigned yoff);
        return (yoff % 4 == 0) && ((yoff % 100 != 0) || (yoff % 400 == 0));
    endfunction

    function automatic int unsigned day_number(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                               logic [DAY_W-1:0] dy);
        int unsigned y;
        int unsigned m;
        int unsigned n;
        y = (yr >= NUM_YEARS) ? NUM_YEARS - 1 : 32'(yr);
        m = (mo < 1) ? 1 : ((mo > 12) ? 12 : 32'(mo));
        n = (dy < 1) ? 0 : 32'(dy) - 1;
        for (int unsigned k = 0; k < y; k++) n += yoff_is_leap(k) ? 366 : 365;
        for (int unsigned k = 1; k < m; k++) n += MONTH_DAYS[k-1];
        if (yoff_is_leap(y) && m > 2) n++;
        return (n > LAST_DAY) ? LAST_DAY : n;
    endfunction

    function automatic void ledger_apply(t_ledger_word w);
        int unsigned lo;
        int unsigned hi;
        t_income     share;
        t_income     sum;
        t_income     s;
        lo = day_number(w.open_year, w.open_month, w.open_day);
        hi = day_number(w.close_year, w.close_month, w.close_day);
        if (w.op == OP_EARN) begin
            if (lo <= hi) begin
                share = (t_income'(w.amount) << FRAC_BITS) / t_income'(hi - lo + 1);
                for (int unsigned i = lo; i <= hi; i++) begin
                    s = ledger_day[i] + share;
                    ledger_day[i] = (s < share) ? '1 : s;
                end
            end
        end else begin
            sum = '0;
            if (lo <= hi) begin
                for (int unsigned i = lo; i <= hi; i++) begin
                    s = sum + ledger_day[i];
                    sum = (s < sum) ? '1 : s;
                end
            end
            income_due.push_back(sum);
        end
    endfunction

    function automatic t_ledger_word date_word(t_op op, int unsigned fy, int unsigned fm,
                                               int unsigned fd, int unsigned ty, int unsigned tm,
                                               int unsigned td, int unsigned amt);
        t_ledger_word w;
        w.op          = op;
        w.open_year   = YEAR_W'(fy);
        w.open_month  = MONTH_W'(fm);
        w.open_day    = DAY_W'(fd);
        w.close_year  = YEAR_W'(ty);
        w.close_month = MONTH_W'(tm);
        w.close_day   = DAY_W'(td);
        w.amount      = AMT_W'(amt);
        return w;
    endfunction

    function automatic t_ledger_word random_word(int unsigned focus_year);
        t_ledger_word w;
        int unsigned  pick;
        pick     = $urandom_range(0, 99);
        w.op     = t_op'($urandom_range(0, 1));
        w.amount = AMT_W'($urandom_range(0, 'hFFFFF));
        if (pick < 10) begin
            w.open_year   = YEAR_W'($urandom_range(0, 127));
            w.open_month  = MONTH_W'($urandom_range(0, 15));
            w.open_day    = DAY_W'($urandom_range(0, 31));
            w.close_year  = YEAR_W'($urandom_range(0, 127));
            w.close_month = MONTH_W'($urandom_range(0, 15));
            w.close_day   = DAY_W'($urandom_range(0, 31));
        end else begin
            if (pick < 14) begin
                w.open_year  = YEAR_W'($urandom_range(0, 3));
                w.close_year = YEAR_W'($urandom_range(96, 99));
            end else begin
                w.open_year  = YEAR_W'(focus_year + $urandom_range(0, 1));
                w.close_year = YEAR_W'(focus_year + $urandom_range(0, 1));
            end
            w.open_month  = MONTH_W'($urandom_range(1, 12));
            w.open_day    = DAY_W'($urandom_range(1, 31));
            w.close_month = MONTH_W'($urandom_range(1, 12));
            w.close_day   = DAY_W'($urandom_range(1, 31));
            if (day_number(w.open_year, w.open_month, w.open_day) >
                day_number(w.close_year, w.close_month, w.close_day) &&
                $urandom_range(0, 9) != 0) begin
                w = date_word(w.op, 32'(w.close_year), 32'(w.close_month), 32'(w.close_day),
                              32'(w.open_year), 32'(w.open_month), 32'(w.open_day),
                              32'(w.amount));
            end
        end
        return w;
    endfunction

    // hand one word to the block; start stays high on return
    task automatic post_word(input t_ledger_word w);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= w.op;
        i_open_year   <= w.open_year;
        i_open_month  <= w.open_month;
        i_open_day    <= w.open_day;
        i_close_year  <= w.close_year;
        i_close_month <= w.close_month;
        i_close_day   <= w.close_day;
        i_amount      <= w.amount;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger_apply(w);
    endtask

    always @(posedge i_clk) begin
        if (o_income_vld === 1'b1) begin
            if (income_due.size() == 0) begin
                $error("income: expected none, actual %h", o_income);
                mismatch_count++;
            end else begin
                income_exp = income_due.pop_front();
                if (o_income !== income_exp) begin
                    $error("income: expected %h, actual %h", income_exp, o_income);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_income_vld === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[day_range_income_ledger_top] ERROR");
            $finish;
        end
    end

    task automatic apply_reset();
        foreach (ledger_day[i]) ledger_day[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_cleared_store();
        post_word(date_word(OP_COMPUTE, 0, 1, 1, 99, 12, 31, 0));
    endtask

    task automatic test_calendar_edges();
        post_word(date_word(OP_EARN, 0, 1, 1, 0, 1, 1, 'hFFFFF));
        post_word(date_word(OP_EARN, 99, 12, 31, 99, 12, 31, 1000000));
        post_word(date_word(OP_EARN, 0, 1, 1, 99, 12, 31, 1000000));
        post_word(date_word(OP_COMPUTE, 0, 1, 1, 0, 1, 1, 0));
        post_word(date_word(OP_COMPUTE, 99, 12, 31, 99, 12, 31, 0));
        post_word(date_word(OP_EARN, 4, 2, 28, 4, 3, 1, 777));
        post_word(date_word(OP_COMPUTE, 4, 2, 29, 4, 2, 29, 0));
        post_word(date_word(OP_EARN, 0, 2, 29, 0, 2, 29, 5000));
        post_word(date_word(OP_COMPUTE, 0, 2, 28, 0, 3, 1, 0));
        post_word(date_word(OP_COMPUTE, 1, 2, 29, 1, 3, 1, 0));
    endtask

    task automatic test_clamped_fields();
        post_word(date_word(OP_EARN, 127, 15, 31, 127, 15, 31, 'hFFFFF));
        post_word(date_word(OP_COMPUTE, 100, 12, 31, 99, 12, 31, 0));
        post_word(date_word(OP_EARN, 50, 0, 0, 50, 0, 0, 4242));
        post_word(date_word(OP_COMPUTE, 50, 1, 1, 50, 1, 2, 'hFFFFF));
        post_word(date_word(OP_EARN, 3, 2, 31, 3, 4, 31, 9999));
        post_word(date_word(OP_COMPUTE, 3, 3, 3, 3, 5, 1, 0));
        post_word(date_word(OP_COMPUTE, 3, 5, 1, 3, 5, 1, 0));
    endtask

    task automatic test_reversed_ranges();
        post_word(date_word(OP_EARN, 10, 6, 1, 10, 5, 31, 123456));
        post_word(date_word(OP_COMPUTE, 10, 5, 31, 10, 6, 1, 0));
        post_word(date_word(OP_COMPUTE, 10, 6, 1, 10, 5, 31, $urandom_range(0, 'hFFFFF)));
        post_word(date_word(OP_COMPUTE, 0, 1, 1, 99, 12, 31, 0));
    endtask

    task automatic test_random_ledger();
        int unsigned focus_year;
        for (int g = 0; g < 4; g++) begin
            idle_on    = (g % 2 == 0);
            focus_year = $urandom_range(0, 99);
            repeat (15) post_word(random_word(focus_year));
        end
    endtask

    task automatic test_back_to_back();
        int unsigned focus_year;
        idle_on    = 1'b0;
        focus_year = $urandom_range(0, 99);
        repeat (20) post_word(random_word(focus_year));
    endtask

    initial begin
        apply_reset();
        test_cleared_store();
        test_calendar_edges();
        test_clamped_fields();
        test_reversed_ranges();
        test_random_ledger();
        test_back_to_back();
        start <= 1'b0;
        while (income_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[day_range_income_ledger_top] OK");
        end else begin
            $display("[day_range_income_ledger_top] ERROR");
        end
        $finish;
    end

endmodule
